>>> rtl/matrix_multiply_transpose_modes_macros.svh
// assertion helpers used by matrix_multiply_transpose_modes.sv
`ifndef MATRIX_MULTIPLY_TRANSPOSE_MODES_MACROS_SVH
`define MATRIX_MULTIPLY_TRANSPOSE_MODES_MACROS_SVH

// same-cycle implication, off during reset
`define MMT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define MMT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mmt_pkg.sv
package mmt_pkg;

    localparam int MAX_DIM     = 8;
    localparam int IDX_W       = 3;
    localparam int DIM_W       = 4;
    localparam int VALUE_W     = 32;
    localparam int PROD_W      = 2 * VALUE_W;
    localparam int FRAC_BITS   = 16;
    localparam int ACC_W       = 52;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 2 * IDX_W;

    // item kinds
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    // product modes
    localparam logic [1:0] MODE_AB  = 2'd0;
    localparam logic [1:0] MODE_ATB = 2'd1;
    localparam logic [1:0] MODE_ABT = 2'd2;

    // register indexes
    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_INNER = 2'd1;
    localparam logic [1:0] REG_COLS  = 2'd2;
    localparam logic [1:0] REG_MODE  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = d;
        end
        return r;
    endfunction

endpackage

>>> rtl/mmt_ram.sv
module mmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/mmt_mac.sv
module mmt_mac (
    input  logic                          aclk,
    input  mmt_pkg::mac_ctrl_t            ctrl,
    input  logic [mmt_pkg::VALUE_W-1:0]   a_data,
    input  logic [mmt_pkg::VALUE_W-1:0]   b_data,
    output logic [mmt_pkg::VALUE_W-1:0]   sat_value,
    output logic                          sat_flag
);
    import mmt_pkg::*;

    localparam int SHIFT_W = PROD_W - FRAC_BITS;

    localparam logic signed [ACC_W-1:0] ACC_MAX =
        {{(ACC_W-VALUE_W){1'b0}}, 1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN =
        {{(ACC_W-VALUE_W){1'b1}}, 1'b1, {(VALUE_W-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  term;

    // floor to q16.16 is the arithmetic shift, then sign extension
    assign term = {{(ACC_W-SHIFT_W){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:FRAC_BITS]};

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (ctrl.acc_en) begin
            acc_next = acc_reg + term;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= $signed(a_data) * $signed(b_data);
        end
        acc_reg <= acc_next;
    end

    always_comb begin
        sat_flag  = 1'b0;
        sat_value = acc_reg[VALUE_W-1:0];
        if (acc_reg > ACC_MAX) begin
            sat_flag  = 1'b1;
            sat_value = ACC_MAX[VALUE_W-1:0];
        end else if (acc_reg < ACC_MIN) begin
            sat_flag  = 1'b1;
            sat_value = ACC_MIN[VALUE_W-1:0];
        end
    end

endmodule

>>> rtl/matrix_multiply_transpose_modes.sv
// channel   dir   handshake             payload
// s_        in    s_tvalid / s_tready   tdata: row, col, value; tuser: op
// m_        out   m_tvalid / m_tready   tdata: row, col, value; tuser: sat; tlast
// cfg_      in    cfg_wr_en             cfg_index, cfg_wdata
//
// a load item writes one entry of store a or b
// a start item computes R*C elements of K terms each and waits on any output stall:
//   each multiply-accumulate goes ram read, multiplier register, accumulator add
// the output register parts the sides; the block takes new items once the
//   final result of a start sits in that register
// reset sets rows, inner and cols to 1 and mode to a*b; store contents
//   are undefined until written
`include "matrix_multiply_transpose_modes_macros.svh"

module matrix_multiply_transpose_modes (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // elem_row[2:0], elem_col[5:3], elem_value[37:6], zero
    input  logic [1:0]  s_tuser,    // op[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // out_row[2:0], out_col[5:3], out_value[37:6], zero
    output logic        m_tuser,    // saturated
    output logic        m_tlast,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_wdata
);
    import mmt_pkg::*;

    // input fields
    logic [1:0]         in_op;
    logic [IDX_W-1:0]   in_row;
    logic [IDX_W-1:0]   in_col;
    logic [VALUE_W-1:0] in_value;

    assign in_op    = s_tuser;
    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[5:3];
    assign in_value = s_tdata[37:6];

    // configuration
    logic [DIM_W-1:0] rows_reg,  rows_next;
    logic [DIM_W-1:0] inner_reg, inner_next;
    logic [DIM_W-1:0] cols_reg,  cols_next;
    logic [1:0]       mode_reg,  mode_next;

    always_comb begin
        rows_next  = rows_reg;
        inner_next = inner_reg;
        cols_next  = cols_reg;
        mode_next  = mode_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROWS:  rows_next  = cfg_wdata;
                REG_INNER: inner_next = cfg_wdata;
                REG_COLS:  cols_next  = cfg_wdata;
                REG_MODE:  mode_next  = cfg_wdata[1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= DIM_W'(1);
            inner_reg <= DIM_W'(1);
            cols_reg  <= DIM_W'(1);
            mode_reg  <= MODE_AB;
        end else begin
            rows_reg  <= rows_next;
            inner_reg <= inner_next;
            cols_reg  <= cols_next;
            mode_reg  <= mode_next;
        end
    end

    // effective dimensions, out-of-range sizes folded into 1..MAX_DIM
    logic [DIM_W-1:0] nr, nk, nc;
    assign nr = clamp_dim(rows_reg);
    assign nk = clamp_dim(inner_reg);
    assign nc = clamp_dim(cols_reg);

    // sequencer
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             i_last, j_last, k_last;
    logic             out_free;
    logic             out_load;
    mac_ctrl_t        mac_ctrl;

    assign i_last   = ({1'b0, i_reg} == nr - DIM_W'(1));
    assign j_last   = ({1'b0, j_reg} == nc - DIM_W'(1));
    assign k_last   = ({1'b0, k_reg} == nk - DIM_W'(1));
    assign out_free = !m_tvalid || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        out_load   = 1'b0;
        mac_ctrl   = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && in_op == OP_START) begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                // fresh sum at the first term of each element
                mac_ctrl.clear = (k_reg == '0);
                state_next     = ST_MUL;
            end
            ST_MUL: begin
                mac_ctrl.mul_en = 1'b1;
                state_next      = ST_ACC;
            end
            ST_ACC: begin
                mac_ctrl.acc_en = 1'b1;
                if (k_last) begin
                    state_next = ST_PUT;
                end else begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_PUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    k_next     = '0;
                    state_next = ST_READ;
                    if (j_last) begin
                        j_next = '0;
                        if (i_last) begin
                            state_next = ST_IDLE;
                        end else begin
                            i_next = i_reg + IDX_W'(1);
                        end
                    end else begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // element stores, addressed row*8+col
    logic               a_wr_en, b_wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  a_rd_addr, b_rd_addr;
    logic [VALUE_W-1:0] a_rd_data, b_rd_data;

    assign a_wr_en = s_tvalid && s_tready && in_op == OP_LOAD_A;
    assign b_wr_en = s_tvalid && s_tready && in_op == OP_LOAD_B;
    assign wr_addr = {in_row, in_col};

    // mode 3 falls through to plain a*b
    assign a_rd_addr = (mode_reg == MODE_ATB) ? {k_reg, i_reg} : {i_reg, k_reg};
    assign b_rd_addr = (mode_reg == MODE_ABT) ? {j_reg, k_reg} : {k_reg, j_reg};

    mmt_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store_a (
        .aclk    (aclk),
        .wr_en   (a_wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    mmt_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store_b (
        .aclk    (aclk),
        .wr_en   (b_wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    // shared multiply-accumulate unit
    logic [VALUE_W-1:0] sat_value;
    logic               sat_flag;

    mmt_mac u_mac (
        .aclk      (aclk),
        .ctrl      (mac_ctrl),
        .a_data    (a_rd_data),
        .b_data    (b_rd_data),
        .sat_value (sat_value),
        .sat_flag  (sat_flag)
    );

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]   out_row_reg;
    logic [IDX_W-1:0]   out_col_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_sat_reg;
    logic               out_last_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_row_reg   <= i_reg;
            out_col_reg   <= j_reg;
            out_value_reg <= sat_value;
            out_sat_reg   <= sat_flag;
            out_last_reg  <= i_last && j_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_col_reg, out_row_reg};
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_last_reg;

    // checks
    `MMT_ASSERT_NEXT(a_acc_done_to_put, aclk, aresetn,
        state_reg == ST_ACC && k_last, state_reg == ST_PUT, "sum not handed to output")
    `MMT_ASSERT_NEXT(a_final_to_idle, aclk, aresetn,
        out_load && i_last && j_last, state_reg == ST_IDLE && m_tlast, "final element lost")
    `MMT_ASSERT_SAME(a_index_range, aclk, aresetn,
        state_reg != ST_IDLE,
        {1'b0, i_reg} < nr && {1'b0, j_reg} < nc && {1'b0, k_reg} < nk,
        "index past dimension")
    `MMT_ASSERT_SAME(a_sat_value, aclk, aresetn,
        m_tvalid && m_tuser,
        m_tdata[37:6] == 32'h7FFF_FFFF || m_tdata[37:6] == 32'h8000_0000,
        "clipped element not at a limit")

endmodule
